### hdl/set_assoc_cache_replacement_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set associative cache replacement block
// Shared property wrappers, clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_REPLACEMENT_ASSERT_SVH
`define SET_ASSOC_CACHE_REPLACEMENT_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define SACR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SACR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hdl/sacr_pkg.sv
// ----------------------------------------------------------------------------
// sacr_pkg
// Types and constants of the set associative cache replacement block.
// ----------------------------------------------------------------------------
package sacr_pkg;

  localparam int unsigned TotalBlocksDefault = 64;
  localparam int unsigned AddrW   = 31;
  localparam int unsigned WayW    = 6;
  localparam int unsigned RankW   = 6;
  localparam int unsigned CntW    = 32;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned MaxLog2 = 6;

  // policy codes
  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LIFO = 2'd1;
  localparam logic [1:0] POL_LRU  = 2'd2;
  localparam logic [1:0] POL_MRU  = 2'd3;

  // register indexes
  localparam logic REG_POLICY    = 1'b0;
  localparam logic REG_WAYS_LOG2 = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DECIDE,
    ST_UPD,
    ST_FIN
  } state_e;

endpackage

### hdl/sacr_ram.sv
// ----------------------------------------------------------------------------
// sacr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/set_assoc_cache_replacement.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_replacement
// Set associative cache directory with FIFO, LIFO, LRU and MRU replacement.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat                     Fields (low bit up)
// s_axis    in   one block address        address[30:0]
// m_axis    out  one lookup result        hit, way, evicted, evicted_address,
//                                         hit_total, miss_total
// cfg       in   register write, no wait  policy (idx 0), ways_log2 (idx 1)
//
// Steps: one item goes through a bit-serial set index remainder, a read
// pass over the set, a decide step, a read-modify-write rank pass (skipped
// on FIFO/LIFO hits) and a finish step. The tag and rank RAMs each have a
// single read port, on one shared address, which sets the pass length.
// Reset: a clearing pass over every block entry zeroes valid bits and ranks;
// no item is taken until it ends. Configuration is taken at any time.
// Stalls: the result sits in an output register; the next item is taken
// while it waits, and only the finish step holds if it is still not taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_replacement #(
  parameter int unsigned TOTAL_BLOCKS = sacr_pkg::TotalBlocksDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // address[30:0], zero padded
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sacr_pkg::InDataW-1:0]  s_axis_tdata,
  // hit[0], way[6:1], evicted[7], evicted_address[38:8],
  // hit_total[70:39], miss_total[102:71], zero pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sacr_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [2:0]                    cfg_data_i
);
  import sacr_pkg::*;

  localparam int unsigned IW   = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
  localparam int unsigned FLOG = $clog2(TOTAL_BLOCKS + 1) - 1;
  localparam int unsigned KMAX = (FLOG < MaxLog2) ? FLOG : MaxLog2;
  localparam int unsigned RW   = $clog2(TOTAL_BLOCKS + 1) + 1;
  localparam int unsigned MW   = RankW + 1;

  // configuration
  logic [1:0] policy_q;
  logic [2:0] ways_log2_q;

  // sequencer
  state_e state_q, state_d;
  logic [IW:0]      clr_q;
  logic [4:0]       bit_q;
  logic [AddrW-1:0] addr_q, shift_q;
  logic [RW-1:0]    rem_q;
  logic [IW-1:0]    base_q;
  logic [WayW:0]    i_q;
  logic             p_q;
  logic [WayW-1:0]  pw_q;

  // scan results
  logic             hit_f_q, emp_f_q;
  logic [WayW-1:0]  hit_w_q, emp_w_q, vic_w_q;
  logic [RankW-1:0] hit_r_q, vic_r_q;
  logic [AddrW-1:0] vic_a_q;

  // decision
  logic [WayW-1:0]  w_q;
  logic [MW-1:0]    limit_q;
  logic             hit_q, ev_q;
  logic [AddrW-1:0] ev_a_q;
  logic [CntW-1:0]  hit_cnt_q, miss_cnt_q;

  logic [OutDataW-1:0] out_q;
  logic                out_v_q;

  // effective layout
  logic [2:0]       k;
  logic [WayW:0]    ways;
  logic [WayW-1:0]  last_w;
  logic [RW-1:0]    sets;
  logic [RW-1:0]    rem_sh, rem_nx;

  always_comb begin
    k      = (ways_log2_q > 3'(KMAX)) ? 3'(KMAX) : ways_log2_q;
    ways   = (WayW+1)'(1) << k;
    last_w = WayW'(ways - 1'b1);
    sets   = RW'(TOTAL_BLOCKS) >> k;
    rem_sh = {rem_q[RW-2:0], shift_q[AddrW-1]};
    rem_nx = (rem_sh >= sets) ? rem_sh - sets : rem_sh;
  end

  // RAM ports
  logic             tag_we, meta_we;
  logic [IW-1:0]    tag_waddr, meta_waddr, raddr;
  logic [MW-1:0]    meta_wdata, meta_rd;
  logic [AddrW-1:0] tag_rd;

  sacr_ram #(.Width(AddrW), .Depth(TOTAL_BLOCKS)) u_tag_ram (
    .clk_i, .we_i(tag_we), .waddr_i(tag_waddr), .wdata_i(addr_q),
    .raddr_i(raddr), .rdata_o(tag_rd)
  );

  sacr_ram #(.Width(MW), .Depth(TOTAL_BLOCKS)) u_meta_ram (
    .clk_i, .we_i(meta_we), .waddr_i(meta_waddr), .wdata_i(meta_wdata),
    .raddr_i(raddr), .rdata_o(meta_rd)
  );

  logic             rd_valid;
  logic [RankW-1:0] rd_rank;
  logic [RankW-1:0] new_rank;

  assign rd_valid = meta_rd[RankW];
  assign rd_rank  = meta_rd[RankW-1:0];
  assign raddr    = base_q + IW'(i_q);
  assign tag_waddr = base_q + IW'(w_q);

  // rank update of the line read back in the update pass
  always_comb begin
    new_rank = rd_rank;
    if (rd_valid && ({1'b0, rd_rank} < limit_q) && (rd_rank != {RankW{1'b1}})) begin
      new_rank = rd_rank + 1'b1;
    end
  end

  logic dec_upd;
  logic scan_done;
  assign scan_done = p_q && (pw_q == last_w);

  // next state and RAM writes
  always_comb begin
    state_d    = state_q;
    meta_we    = 1'b0;
    meta_waddr = base_q + IW'(pw_q);
    meta_wdata = (pw_q == w_q) ? {1'b1, {RankW{1'b0}}} : {rd_valid, new_rank};
    tag_we     = 1'b0;
    dec_upd    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q[IW-1:0];
        meta_wdata = '0;
        if (clr_q == (IW+1)'(TOTAL_BLOCKS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_MOD;
      end
      ST_MOD: begin
        if (bit_q == 5'(AddrW - 1)) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        dec_upd = !hit_f_q || policy_q == POL_LRU || policy_q == POL_MRU;
        state_d = dec_upd ? ST_UPD : ST_FIN;
      end
      ST_UPD: begin
        // store the new tag once the chosen way is registered
        tag_we  = !hit_q && (i_q == '0);
        meta_we = p_q;
        if (scan_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_v_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      policy_q    <= POL_FIFO;
      ways_log2_q <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_v_q     <= 1'b0;
      p_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POLICY:    policy_q    <= cfg_data_i[1:0];
          REG_WAYS_LOG2: ways_log2_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      // read pipeline flag: a read was issued last cycle
      p_q <= (state_q == ST_SCAN || state_q == ST_UPD) && (i_q < ways);
      if (state_q == ST_DECIDE) begin
        if (hit_f_q) begin
          if (hit_cnt_q != {CntW{1'b1}}) hit_cnt_q <= hit_cnt_q + 1'b1;
        end else if (miss_cnt_q != {CntW{1'b1}}) begin
          miss_cnt_q <= miss_cnt_q + 1'b1;
        end
      end
      if (m_axis_tready) out_v_q <= 1'b0;
      if (state_q == ST_FIN && (!out_v_q || m_axis_tready)) out_v_q <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        addr_q  <= s_axis_tdata[AddrW-1:0];
        shift_q <= s_axis_tdata[AddrW-1:0];
        rem_q   <= '0;
        bit_q   <= '0;
      end
      ST_MOD: begin
        // one remainder bit per cycle
        rem_q   <= rem_nx;
        shift_q <= {shift_q[AddrW-2:0], 1'b0};
        bit_q   <= bit_q + 1'b1;
        base_q  <= IW'(rem_nx) << k;
        i_q     <= '0;
        hit_f_q <= 1'b0;
        emp_f_q <= 1'b0;
      end
      ST_SCAN: begin
        if (i_q < ways) i_q <= i_q + 1'b1;
        pw_q <= WayW'(i_q);
        if (p_q) begin
          if (!hit_f_q && rd_valid && tag_rd == addr_q) begin
            hit_f_q <= 1'b1;
            hit_w_q <= pw_q;
            hit_r_q <= rd_rank;
          end
          if (!emp_f_q && !rd_valid) begin
            emp_f_q <= 1'b1;
            emp_w_q <= pw_q;
          end
          // victim candidate: lowest way wins ties; LIFO takes the last way
          if (pw_q == '0 || policy_q == POL_LIFO ||
              (policy_q == POL_MRU && rd_rank < vic_r_q) ||
              (policy_q != POL_MRU && rd_rank > vic_r_q)) begin
            vic_w_q <= pw_q;
            vic_r_q <= rd_rank;
            vic_a_q <= tag_rd;
          end
        end
      end
      ST_DECIDE: begin
        i_q   <= '0;
        hit_q <= hit_f_q;
        ev_q  <= !hit_f_q && !emp_f_q;
        if (hit_f_q) begin
          w_q     <= hit_w_q;
          limit_q <= {1'b0, hit_r_q};
          ev_a_q  <= '0;
        end else if (emp_f_q) begin
          w_q     <= emp_w_q;
          limit_q <= {1'b1, {RankW{1'b0}}};
          ev_a_q  <= '0;
        end else begin
          w_q     <= vic_w_q;
          limit_q <= {1'b0, vic_r_q};
          ev_a_q  <= vic_a_q;
        end
      end
      ST_UPD: begin
        if (i_q < ways) i_q <= i_q + 1'b1;
        pw_q <= WayW'(i_q);
      end
      ST_FIN: begin
        if (!out_v_q || m_axis_tready) begin
          out_q <= {1'b0, miss_cnt_q, hit_cnt_q, ev_a_q, ev_q, w_q, hit_q};
        end
      end
      default: ;
    endcase
  end

`include "set_assoc_cache_replacement_assert.svh"

  `SACR_ASSERT(a_out_from_fin, $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN), "result without finish")
  `SACR_NEVER(a_hit_no_evict, m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[7], "hit with eviction")
  `SACR_ASSERT(a_hit_cnt_mono, 1'b1 |=> hit_cnt_q >= $past(hit_cnt_q), "hit count went down")
  `SACR_ASSERT(a_miss_cnt_mono, 1'b1 |=> miss_cnt_q >= $past(miss_cnt_q), "miss count went down")

endmodule

### verif/tb_set_assoc_cache_replacement.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_replacement
// Self-checking bench for the set associative cache replacement block: a
// behavioral cache directory predicts every lookup result, and each result
// beat is compared field by field while both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_replacement;
  import sacr_pkg::*;

  localparam int unsigned Blocks     = 64;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned IdleTail   = 200;
  localparam logic [30:0] AddrMask   = 31'h7FFF_FFFF;

  // One lookup result, as the block reports it.
  typedef struct packed {
    logic        hit;
    logic [5:0]  way;
    logic        evicted;
    logic [30:0] evicted_address;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // address[30:0], zero padded
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // hit, way[5:0], evicted, evicted_address[30:0], hit_total, miss_total
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [2:0] cfg_data_i = '0;

  set_assoc_cache_replacement #(.TOTAL_BLOCKS(Blocks)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Shadow directory: the bench's own copy of the cache state.
  logic [30:0] dir_addr [Blocks];
  logic        dir_valid[Blocks];
  logic [5:0]  dir_age  [Blocks];
  logic [31:0] hits_seen, misses_seen;
  logic [1:0]  cur_policy;
  logic [2:0]  cur_ways_log2;

  lookup_t pending_lookups[$];
  int unsigned error_count = 0;
  int unsigned beats_sent = 0, beats_checked = 0, hit_beats = 0, evict_beats = 0;
  bit quiet = 1'b0;        // no random idling on either side
  bit hold_request = 1'b0; // ask the receiver for a long hold-off
  int unsigned idle_cycles = 0;

  // Make way w of the set the newest; valid lines younger than limit age by one.
  function automatic void make_newest(int unsigned base, int unsigned ways,
                                      int unsigned w, int unsigned limit);
    for (int unsigned i = 0; i < ways; i++) begin
      if (i != w && dir_valid[base + i] && dir_age[base + i] < limit &&
          dir_age[base + i] < 6'd63)
        dir_age[base + i]++;
    end
    dir_age[base + w] = '0;
  endfunction

  // Predict one lookup and update the shadow directory.
  function automatic lookup_t lookup_address(logic [30:0] addr);
    lookup_t r;
    int unsigned k, ways, sets, base, w;
    bit found;
    k = (cur_ways_log2 > 3'd6) ? 6 : cur_ways_log2;
    ways = 1 << k;
    sets = Blocks >> k;
    base = (addr % sets) * ways;
    r = '0;
    w = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < ways; i++) begin
      if (!found && dir_valid[base + i] && dir_addr[base + i] == addr) begin
        found = 1'b1;
        w = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (hits_seen != '1) hits_seen++;
      if (cur_policy == POL_LRU || cur_policy == POL_MRU)
        make_newest(base, ways, w, dir_age[base + w]);
    end else begin
      if (misses_seen != '1) misses_seen++;
      for (int unsigned i = 0; i < ways; i++) begin
        if (!found && !dir_valid[base + i]) begin
          found = 1'b1;
          w = i;
        end
      end
      if (found) begin
        dir_addr[base + w] = addr;
        dir_valid[base + w] = 1'b1;
        make_newest(base, ways, w, 64);
      end else begin
        if (cur_policy == POL_LIFO) begin
          w = ways - 1;
        end else begin
          w = 0;
          for (int unsigned i = 1; i < ways; i++) begin
            if (cur_policy == POL_MRU ? dir_age[base + i] < dir_age[base + w]
                                      : dir_age[base + i] > dir_age[base + w])
              w = i;
          end
        end
        r.evicted = 1'b1;
        r.evicted_address = dir_addr[base + w];
        dir_addr[base + w] = addr;
        make_newest(base, ways, w, dir_age[base + w]);
      end
    end
    r.way = w[5:0];
    r.hit_total = hits_seen;
    r.miss_total = misses_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH beat %0d %s: got 0x%0h expected 0x%0h",
             beats_checked, what, got, want);
    error_count++;
  endtask

  // Offer one address; hold it until the block takes it.
  task automatic send_address(logic [30:0] addr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_lookups.push_back(lookup_address(addr));
    beats_sent++;
  endtask

  // Drop valid and wait until every result is back and the block is quiet.
  task automatic drain;
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [2:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_POLICY) cur_policy = value[1:0];
    else cur_ways_log2 = value;
  endtask

  task automatic configure(logic [1:0] pol, logic [2:0] wl2);
    drain();
    write_reg(REG_POLICY, {1'b0, pol});
    write_reg(REG_WAYS_LOG2, wl2);
  endtask

  // Run a stream of lookups over a small pool of addresses packed into one or
  // two sets, so that hits and evictions dominate; a few cold misses mixed in.
  task automatic run_pool(int unsigned count);
    logic [30:0] pool[$];
    int unsigned k, sets, nsets, npool;
    logic [30:0] a;
    k = (cur_ways_log2 > 3'd6) ? 6 : cur_ways_log2;
    sets = Blocks >> k;
    nsets = (sets > 1) ? 2 : 1;
    npool = (1 << k) * nsets + $urandom_range(1, 4);
    for (int unsigned i = 0; i < npool; i++) begin
      a = 31'($urandom());
      a = (a & ~31'(sets - 1)) | 31'($urandom_range(0, nsets - 1) % sets);
      pool.push_back(a);
    end
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_address(31'($urandom()));
      else send_address(pool[$urandom_range(0, npool - 1)]);
    end
  endtask

  // Fill and overflow set 0 of a two-way layout under each policy, then the
  // address extremes, the direct-mapped layout and oversized associativity.
  task automatic test_directed;
    for (int p = 0; p < 4; p++) begin
      configure(p[1:0], 3'd1);
      send_address(31'd0);
      send_address(31'd32);
      send_address(31'd0);
      send_address(31'd64);
      send_address(31'd32);
    end
    configure(POL_FIFO, 3'd0);
    send_address(AddrMask);
    send_address(31'd63);
    configure(POL_LRU, 3'd7);
    send_address(AddrMask);
    send_address(31'h5555_5555);
    send_address(AddrMask);
  endtask

  // Sweep every policy against every associativity, without flushing between.
  task automatic test_random_sweep;
    for (int w = 0; w < 8; w++) begin
      for (int p = 0; p < 4; p++) begin
        configure(p[1:0], w[2:0]);
        run_pool($urandom_range(30, 50));
      end
    end
  endtask

  // Hold the receiver off long enough to fill the block while items keep coming.
  task automatic test_backpressure;
    configure(POL_LRU, 3'd2);
    hold_request = 1'b1;
    run_pool(60);
    configure(POL_MRU, 3'd6);
    run_pool(60);
  endtask

  // Last stretch with no idling on either side.
  task automatic test_streaming;
    configure(POL_FIFO, 3'd3);
    quiet = 1'b1;
    run_pool(80);
  endtask

  // Result side: random stalls, the long hold-off, and the field checks.
  int unsigned hold_left = 0, stall_left = 0;
  always @(posedge clk_i) begin
    lookup_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[6:1], m_axis_tdata[7], m_axis_tdata[38:8],
             m_axis_tdata[70:39], m_axis_tdata[102:71]};
      if (pending_lookups.size() == 0) begin
        $display("MISMATCH result beat with nothing expected");
        error_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (got.hit != want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.way != want.way) report_mismatch("way", 32'(got.way), 32'(want.way));
        if (got.evicted != want.evicted)
          report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
        if (got.evicted_address != want.evicted_address)
          report_mismatch("evicted_address", 32'(got.evicted_address),
                          32'(want.evicted_address));
        if (got.hit_total != want.hit_total)
          report_mismatch("hit_total", got.hit_total, want.hit_total);
        if (got.miss_total != want.miss_total)
          report_mismatch("miss_total", got.miss_total, want.miss_total);
        hit_beats += got.hit;
        evict_beats += got.evicted;
      end
      beats_checked++;
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if no beat moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("timeout: no beat for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Blocks; i++) begin
      dir_addr[i] = '0;
      dir_valid[i] = 1'b0;
      dir_age[i] = '0;
    end
    hits_seen = '0;
    misses_seen = '0;
    cur_policy = POL_FIFO;
    cur_ways_log2 = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_sweep();
    test_backpressure();
    test_streaming();
    drain();
    $display("covered %0d lookups: %0d hits, %0d evictions", beats_checked, hit_beats,
             evict_beats);
    $display("all four policies at associativity 1 to 64, oversized setting included");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/sacr_pkg.sv
hdl/sacr_ram.sv
hdl/set_assoc_cache_replacement.sv
verif/tb_set_assoc_cache_replacement.sv
